@@ design/slsp_pkg.sv @@
`default_nettype none
package slsp_pkg;
	localparam int NPKT = 7;
	localparam int PW = 40;

	typedef enum logic [2:0] {
		OP_SYM = 3'd0, OP_DIG = 3'd1, OP_TCH = 3'd2, OP_BCH = 3'd3,
		OP_CLR = 3'd4, OP_FLUSH = 3'd5, OP_BL = 3'd6, OP_INIT = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0] pkt;
		logic [5:0] bit_pos;
	} bitref_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;     // capture input transaction
		logic       apply;    // write captured display command into shadow
		logic       zero;     // zero all payloads
		logic       clr_mask; // clear dirty mask
		logic       emit;     // load output register
		logic [2:0] sel;      // packet number for emit
		logic [1:0] src;      // 0 status, 1 packet, 2 backlight, 3 init
		logic       status;
		logic       last;
	} cmd_t;

	localparam logic [1:0] SRC_STAT = 2'd0;
	localparam logic [1:0] SRC_PKT  = 2'd1;
	localparam logic [1:0] SRC_BL   = 2'd2;
	localparam logic [1:0] SRC_INIT = 2'd3;

	function automatic logic [7:0] pkt_hi(input logic [2:0] p);
		return (p == 3'd6) ? 8'h61 : 8'hC1;
	endfunction

	function automatic logic [7:0] pkt_lo(input logic [2:0] p);
		logic [7:0] r;
		case (p)
			3'd0: r = 8'h40;
			3'd1: r = 8'h45;
			3'd2: r = 8'h4A;
			3'd3: r = 8'h4F;
			3'd4: r = 8'h54;
			3'd5: r = 8'h59;
			3'd6: r = 8'h5E;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic bitref_t br(input int p, input int b);
		bitref_t r;
		r.pkt = 3'(p);
		r.bit_pos = 6'(b);
		return r;
	endfunction

	function automatic bitref_t sym_ref(input logic [4:0] i);
		bitref_t r;
		case (i)
			5'd0: r = br(0, 21);  5'd1: r = br(0, 22);  5'd2: r = br(1, 7);
			5'd3: r = br(2, 5);   5'd4: r = br(2, 6);   5'd5: r = br(2, 7);
			5'd6: r = br(3, 5);   5'd7: r = br(3, 6);   5'd8: r = br(3, 7);
			5'd9: r = br(3, 30);  5'd10: r = br(3, 31); 5'd11: r = br(4, 29);
			5'd12: r = br(4, 30); 5'd13: r = br(4, 39); 5'd14: r = br(5, 7);
			5'd15: r = br(5, 15); 5'd16: r = br(5, 23); 5'd17: r = br(5, 31);
			default: r = br(6, 7);
		endcase
		return r;
	endfunction

	// Packet/bit of segment s of digit d; the packet is the same for all segments but for digit 2
	function automatic bitref_t dig_ref(input logic [3:0] d, input logic [2:0] s);
		int b [7];
		int p;
		case (d)
			4'd1: begin p = 4; b = '{16, 21, 23, 15, 22, 13, 14}; end
			4'd4: begin p = 3; b = '{8, 13, 23, 15, 21, 14, 22}; end
			4'd5: begin p = 0; b = '{8, 13, 7, 15, 5, 14, 6}; end
			4'd6: begin p = 0; b = '{32, 37, 31, 39, 29, 38, 30}; end
			4'd7: begin p = 2; b = '{24, 29, 39, 31, 37, 30, 38}; end
			4'd8: begin p = 2; b = '{8, 13, 23, 15, 21, 14, 22}; end
			4'd9: begin p = 1; b = '{24, 29, 39, 31, 37, 30, 38}; end
			default: begin p = 1; b = '{6, 13, 23, 15, 21, 14, 22}; end
		endcase
		if (d == 4'd2) begin
			case (s)
				3'd0: return br(3, 32);
				3'd1: return br(3, 37);
				3'd2: return br(4, 7);
				3'd3: return br(3, 39);
				3'd4: return br(4, 5);
				3'd5: return br(3, 38);
				default: return br(4, 6);
			endcase
		end
		return br(p, b[s]);
	endfunction

	function automatic bitref_t top_ref(input logic [2:0] c, input logic [3:0] s);
		int g, o;
		bitref_t r;
		g = (s < 4) ? 0 : (s < 9) ? 1 : 2;
		o = (s < 4) ? int'(s) : (s < 9) ? int'(s) - 4 : int'(s) - 9;
		case ({c, 2'(g)})
			5'd0: r = br(4, 17); 5'd1: r = br(4, 8);  5'd2: r = br(4, 24);
			5'd4: r = br(3, 33); 5'd5: r = br(3, 24); 5'd6: r = br(4, 0);
			5'd8: r = br(3, 9);  5'd9: r = br(3, 0);  5'd10: r = br(3, 16);
			5'd12: r = br(0, 9); 5'd13: r = br(0, 16); 5'd14: r = br(0, 0);
			5'd16: r = br(0, 33); 5'd17: r = br(2, 32); 5'd18: r = br(0, 24);
			5'd20: r = br(2, 25); 5'd21: r = br(2, 16); 5'd22: r = br(1, 0);
			5'd24: r = br(2, 9); 5'd25: r = br(2, 0); 5'd26: r = br(1, 8);
			5'd28: r = br(1, 25); 5'd29: r = br(1, 16); default: r = br(1, 32);
		endcase
		r.bit_pos = r.bit_pos + 6'(o);
		return r;
	endfunction

	function automatic bitref_t bot_ref(input logic [1:0] c, input logic [3:0] s);
		int g, o;
		bitref_t r;
		case (s)
			4'd0: begin g = 1; o = 6; end
			4'd1: begin g = 0; o = 4; end
			4'd2: begin g = 1; o = 2; end
			4'd3: begin g = 0; o = 0; end
			4'd4: begin g = 1; o = 5; end
			4'd5: begin g = 1; o = 4; end
			4'd6: begin g = 1; o = 3; end
			4'd7: begin g = 1; o = 1; end
			4'd8: begin g = 1; o = 0; end
			4'd9: begin g = 0; o = 6; end
			4'd10: begin g = 0; o = 5; end
			4'd11: begin g = 0; o = 3; end
			4'd12: begin g = 0; o = 2; end
			default: begin g = 0; o = 1; end
		endcase
		case ({c, 1'(g)})
			3'd0: r = br(4, 32); 3'd1: r = br(5, 0);
			3'd2: r = br(5, 8);  3'd3: r = br(5, 16);
			3'd4: r = br(5, 24); 3'd5: r = br(5, 32);
			3'd6: r = br(6, 0);  default: r = br(6, 8);
		endcase
		r.bit_pos = r.bit_pos + 6'(o);
		return r;
	endfunction
endpackage
`default_nettype wire

@@ design/slsp_datapath.sv @@
`default_nettype none
module slsp_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire slsp_pkg::cmd_t cmd,
	input  wire logic [2:0]     op,
	input  wire logic [4:0]     index,
	input  wire logic [14:0]    value,
	output logic [6:0]          dirty,
	output logic                kind,
	output logic                status,
	output logic [7:0]          cmd_hi,
	output logic [7:0]          cmd_lo,
	output logic [39:0]         payload,
	output logic                last
);
	import slsp_pkg::*;

	logic [2:0]  op_q;
	logic [4:0]  idx_q;
	logic [14:0] val_q;
	logic [39:0] store_q [NPKT];
	logic [6:0]  dirty_q;
	logic [39:0] set_m [NPKT];
	logic [39:0] wr_m [NPKT];
	logic [14:0] v;
	bitref_t     r;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			idx_q <= index;
			val_q <= value;
		end
	end

	// Decode the captured command into per-packet write and set masks
	always_comb begin
		for (int p = 0; p < NPKT; p++) begin
			set_m[p] = '0;
			wr_m[p]  = '0;
		end
		v = val_q;
		if (v[14]) v = v | 15'h0840;
		r = '0;
		case (op_t'(op_q))
			OP_SYM: begin
				r = sym_ref(idx_q);
				wr_m[r.pkt][r.bit_pos] = 1'b1;
				set_m[r.pkt][r.bit_pos] = val_q[0];
			end
			OP_DIG: begin
				if (idx_q == 5'd0) begin
					wr_m[4][31] = 1'b1;
					set_m[4][31] = val_q[7];
				end else if (idx_q == 5'd3) begin
					wr_m[3][29] = 1'b1;
					set_m[3][29] = val_q[7];
				end else begin
					for (int s = 0; s < 7; s++) begin
						r = dig_ref(idx_q[3:0], 3'(s));
						wr_m[r.pkt][r.bit_pos] = 1'b1;
						set_m[r.pkt][r.bit_pos] = val_q[s];
					end
				end
			end
			OP_TCH: begin
				for (int s = 0; s < 14; s++) begin
					r = top_ref(idx_q[2:0], 4'(s));
					wr_m[r.pkt][r.bit_pos] = 1'b1;
					set_m[r.pkt][r.bit_pos] = v[s];
				end
			end
			OP_BCH: begin
				for (int s = 0; s < 14; s++) begin
					r = bot_ref(idx_q[1:0], 4'(s));
					wr_m[r.pkt][r.bit_pos] = 1'b1;
					set_m[r.pkt][r.bit_pos] = v[s];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
			for (int p = 0; p < NPKT; p++) store_q[p] <= '0;
		end else begin
			if (cmd.zero) begin
				for (int p = 0; p < NPKT; p++) store_q[p] <= '0;
			end else if (cmd.apply) begin
				for (int p = 0; p < NPKT; p++) begin
					store_q[p] <= (store_q[p] & ~wr_m[p]) | set_m[p];
					if (|wr_m[p]) dirty_q[p] <= 1'b1;
				end
			end
			if (cmd.clr_mask) dirty_q <= '0;
		end
	end

	// Output register: holds the result until the controller sees it taken
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status <= cmd.status;
			last   <= cmd.last;
			case (cmd.src)
				SRC_PKT: begin
					kind <= 1'b1; cmd_hi <= pkt_hi(cmd.sel);
					cmd_lo <= pkt_lo(cmd.sel); payload <= store_q[cmd.sel];
				end
				SRC_BL: begin
					kind <= 1'b1; cmd_hi <= 8'h64; cmd_lo <= 8'h12;
					payload <= 40'h000000FD01;
				end
				SRC_INIT: begin
					kind <= 1'b1; cmd_hi <= '0; cmd_lo <= '0; payload <= '0;
				end
				default: begin
					kind <= 1'b0; cmd_hi <= '0; cmd_lo <= '0; payload <= '0;
				end
			endcase
		end
	end

	assign dirty = dirty_q;
endmodule
`default_nettype wire

@@ design/slsp_ctrl.sv @@
`default_nettype none
module slsp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [2:0]     op,
	input  wire logic [4:0]     index,
	input  wire logic [6:0]     dirty,
	output logic                out_valid,
	input  wire logic           out_stall,
	output slsp_pkg::cmd_t      cmd
);
	import slsp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001, ST_APPLY = 4'b0010, ST_SWEEP = 4'b0100, ST_WAIT = 4'b1000
	} state_t;

	state_t     state_q;
	logic [2:0] op_q;
	logic [2:0] pos_q;
	logic [6:0] todo_q;
	logic       ovalid_q;
	logic       bad_q;
	logic       bad;
	logic       ofree;
	logic [6:0] rest;

	assign ofree     = !ovalid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ovalid_q;

	always_comb begin
		case (op_t'(op))
			OP_SYM: bad = (index > 5'd18);
			OP_DIG: bad = (index > 5'd10);
			OP_TCH: bad = (index > 5'd7);
			OP_BCH: bad = (index > 5'd3);
			default: bad = 1'b0;
		endcase
	end

	// packets left after the current sweep position
	assign rest = todo_q & ~((7'd2 << pos_q) - 7'd1);

	always_comb begin
		cmd = '0;
		cmd.sel = pos_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				// zero the payloads before a clear sweeps them out
				cmd.zero = in_valid && (op_t'(op) == OP_CLR);
			end
			ST_APPLY: begin
				cmd.apply = ofree;
				cmd.emit  = ofree;
				cmd.src   = SRC_STAT;
				cmd.last  = 1'b1;
			end
			ST_SWEEP: begin
				if (ofree && todo_q[pos_q]) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_PKT;
					cmd.last = (rest == '0);
				end
				cmd.clr_mask = (op_t'(op_q) == OP_FLUSH) && ofree && (rest == '0);
			end
			ST_WAIT: begin
				cmd.emit   = ofree;
				cmd.last   = 1'b1;
				cmd.status = bad_q;
				if (bad_q) cmd.src = SRC_STAT;
				else if (op_t'(op_q) == OP_BL) cmd.src = SRC_BL;
				else if (op_t'(op_q) == OP_INIT) cmd.src = SRC_INIT;
				else cmd.src = SRC_STAT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			op_q     <= '0;
			pos_q    <= '0;
			todo_q   <= '0;
			bad_q    <= 1'b0;
		end else begin
			if (cmd.emit) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q  <= op;
						pos_q <= '0;
						bad_q <= bad;
						case (op_t'(op))
							OP_CLR: begin
								todo_q  <= 7'h7F;
								state_q <= ST_SWEEP;
							end
							OP_FLUSH: begin
								todo_q  <= dirty;
								state_q <= (dirty == '0) ? ST_WAIT : ST_SWEEP;
							end
							OP_BL, OP_INIT: state_q <= ST_WAIT;
							default: state_q <= bad ? ST_WAIT : ST_APPLY;
						endcase
					end
				end
				ST_APPLY: if (ofree) state_q <= ST_IDLE;
				ST_SWEEP: begin
					if (ofree) begin
						if (rest == '0) state_q <= ST_IDLE;
						else pos_q <= pos_q + 3'd1;
					end
				end
				ST_WAIT: if (ofree) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/segment_lcd_shadow_packer_core.sv @@
// Flow: an accepted transaction is handled in ST_APPLY, ST_WAIT or ST_SWEEP,
// which loads its results into the output register; flush and clear visit
// one packet slot per cycle while the output is not stalled, in order, up to
// the last slot they send, set by the sweep counter. One transaction is in
// work at a time, and a stalled waiting result holds the controller.
// Reset: asynchronous, clears shadow payloads, dirty mask and output valid.
`default_nettype none
module segment_lcd_shadow_packer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [4:0]  index,
	input  wire logic [14:0] value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic             status,
	output logic [7:0]       cmd_hi,
	output logic [7:0]       cmd_lo,
	output logic [39:0]      payload,
	output logic             last
);
	import slsp_pkg::*;

	logic [6:0] dirty;
	cmd_t       cmd;

	// controller: accept a transaction only when idle, hold it until all its
	// results are loaded into the output register
	slsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.index     (index),
		.dirty     (dirty),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath: shadow payloads, dirty mask, table decode and output register
	slsp_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.op      (op),
		.index   (index),
		.value   (value),
		.dirty   (dirty),
		.kind    (kind),
		.status  (status),
		.cmd_hi  (cmd_hi),
		.cmd_lo  (cmd_lo),
		.payload (payload),
		.last    (last)
	);

	// a stalled result must not be overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.emit) else $error("result overwritten");
	// an accepted transaction keeps the input stalled on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("accept while busy");
	// a flush that finishes leaves a clean mask
	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_mask |=> (dirty == '0)) else $error("mask not cleared");
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import slsp_pkg::*;

	// one expected result of the packer
	typedef struct {
		logic        kind;
		logic        status;
		logic [7:0]  cmd_hi;
		logic [7:0]  cmd_lo;
		logic [39:0] payload;
		logic        last;
	} lcd_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  op;
	logic [4:0]  index;
	logic [14:0] value;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic        status;
	logic [7:0]  cmd_hi;
	logic [7:0]  cmd_lo;
	logic [39:0] payload;
	logic        last;

	segment_lcd_shadow_packer_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .index(index), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .status(status), .cmd_hi(cmd_hi), .cmd_lo(cmd_lo),
		.payload(payload), .last(last)
	);

	// Shadow copy of the display memory, kept by the predictor
	logic [39:0] shadow_pl [NPKT];
	logic [6:0]  shadow_dirty;
	lcd_result_t pending_results [$];

	int errors = 0;
	int sent_count = 0;
	int result_count = 0;
	int op_seen [8];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ---------------------------------------------------------------
	// Display mapping tables, written as plain lookup by packet/bit
	// ---------------------------------------------------------------
	function automatic void lcd_bit(int p, int b, bit on);
		shadow_pl[p][b] = on;
		shadow_dirty[p] = 1'b1;
	endfunction

	function automatic void map_symbol(int i, output int p, output int b);
		int ps [19] = '{0,0,1,2,2,2,3,3,3,3,3,4,4,4,5,5,5,5,6};
		int bs [19] = '{21,22,7,5,6,7,5,6,7,30,31,29,30,39,7,15,23,31,7};
		p = ps[i];
		b = bs[i];
	endfunction

	function automatic void map_digit(int d, int s, output int p, output int b);
		int dp [11] = '{0,4,0,0,3,0,0,2,2,1,1};
		int db [11][7] = '{
			'{0,0,0,0,0,0,0},
			'{16,21,23,15,22,13,14},
			'{32,37,7,39,5,38,6},
			'{0,0,0,0,0,0,0},
			'{8,13,23,15,21,14,22},
			'{8,13,7,15,5,14,6},
			'{32,37,31,39,29,38,30},
			'{24,29,39,31,37,30,38},
			'{8,13,23,15,21,14,22},
			'{24,29,39,31,37,30,38},
			'{6,13,23,15,21,14,22}};
		p = dp[d];
		// position 2 spans two packets
		if (d == 2 && (s == 2 || s == 4 || s == 6))
			p = 4;
		else if (d == 2)
			p = 3;
		b = db[d][s];
	endfunction

	function automatic void map_top(int c, int s, output int p, output int b);
		int tp [8][3] = '{'{4,4,4},'{3,3,4},'{3,3,3},'{0,0,0},
			'{0,2,0},'{2,2,1},'{2,2,1},'{1,1,1}};
		int tb_ [8][3] = '{'{17,8,24},'{33,24,0},'{9,0,16},'{9,16,0},
			'{33,32,24},'{25,16,0},'{9,0,8},'{25,16,32}};
		int g [14] = '{0,0,0,0,1,1,1,1,1,2,2,2,2,2};
		int o [14] = '{0,1,2,3,0,1,2,3,4,0,1,2,3,4};
		p = tp[c][g[s]];
		b = tb_[c][g[s]] + o[s];
	endfunction

	function automatic void map_bottom(int c, int s, output int p, output int b);
		int bp [4][2] = '{'{4,5},'{5,5},'{5,5},'{6,6}};
		int bb [4][2] = '{'{32,0},'{8,16},'{24,32},'{0,8}};
		int g [14] = '{1,0,1,0,1,1,1,1,1,0,0,0,0,0};
		int o [14] = '{6,4,2,0,5,4,3,1,0,6,5,3,2,1};
		p = bp[c][g[s]];
		b = bb[c][g[s]] + o[s];
	endfunction

	function automatic void push_result(int k, int st, int hi, int lo,
			logic [39:0] pl, int lst);
		lcd_result_t r;
		r.kind = k[0]; r.status = st[0]; r.cmd_hi = hi[7:0]; r.cmd_lo = lo[7:0];
		r.payload = pl; r.last = lst[0];
		pending_results.push_back(r);
	endfunction

	// Apply one command to the shadow and queue the results it produces
	function automatic void predict_lcd(op_t o, logic [4:0] idx, logic [14:0] v);
		int p, b, n, k, ix;
		logic [14:0] cv;
		logic [7:0] his [7] = '{8'hC1,8'hC1,8'hC1,8'hC1,8'hC1,8'hC1,8'h61};
		logic [7:0] los [7] = '{8'h40,8'h45,8'h4A,8'h4F,8'h54,8'h59,8'h5E};
		ix = int'(idx);
		cv = v;
		if (v[14]) begin
			cv[6] = 1'b1;
			cv[11] = 1'b1;
		end
		case (o)
			OP_SYM: begin
				if (ix > 18) begin
					push_result(0, 1, 0, 0, '0, 1);
					return;
				end
				map_symbol(ix, p, b);
				lcd_bit(p, b, v[0]);
			end
			OP_DIG: begin
				if (ix > 10) begin
					push_result(0, 1, 0, 0, '0, 1);
					return;
				end
				// only the decimal point exists at positions 0 and 3
				if (ix == 0) lcd_bit(4, 31, v[7]);
				else if (ix == 3) lcd_bit(3, 29, v[7]);
				else for (int s = 0; s < 7; s++) begin
					map_digit(ix, s, p, b);
					lcd_bit(p, b, v[s]);
				end
			end
			OP_TCH: begin
				if (ix > 7) begin
					push_result(0, 1, 0, 0, '0, 1);
					return;
				end
				for (int s = 0; s < 14; s++) begin
					map_top(ix, s, p, b);
					lcd_bit(p, b, cv[s]);
				end
			end
			OP_BCH: begin
				if (ix > 3) begin
					push_result(0, 1, 0, 0, '0, 1);
					return;
				end
				for (int s = 0; s < 14; s++) begin
					map_bottom(ix, s, p, b);
					lcd_bit(p, b, cv[s]);
				end
			end
			OP_CLR: begin
				for (int i = 0; i < NPKT; i++) begin
					shadow_pl[i] = '0;
					push_result(1, 0, int'(his[i]), int'(los[i]), '0,
						int'(i == NPKT - 1));
				end
				return;
			end
			OP_FLUSH: begin
				n = $countones(shadow_dirty);
				if (n == 0) begin
					push_result(0, 0, 0, 0, '0, 1);
					return;
				end
				k = 0;
				for (int i = 0; i < NPKT; i++)
					if (shadow_dirty[i]) begin
						k++;
						push_result(1, 0, int'(his[i]), int'(los[i]), shadow_pl[i],
							int'(k == n));
					end
				shadow_dirty = '0;
				return;
			end
			OP_BL: begin
				push_result(1, 0, 8'h64, 8'h12, 40'hFD01, 1);
				return;
			end
			default: begin
				push_result(1, 0, 8'h00, 8'h00, '0, 1);
				return;
			end
		endcase
		push_result(0, 0, 0, 0, '0, 1);
	endfunction

	// ---------------------------------------------------------------
	// Sender: drive one transaction, hold it until accepted
	// ---------------------------------------------------------------
	task automatic send_cmd(op_t o, logic [4:0] idx, logic [14:0] v);
		// random idle cycles ahead of the transaction
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		op <= o;
		index <= idx;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_lcd(o, idx, v);
		op_seen[o]++;
		sent_count++;
	endtask

	// Wait until every queued result has come back, then let the block settle
	task automatic drain_results();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
	endtask

	// Receiver: random stall, drop nothing
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		lcd_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind=%0d cmd=%h/%h", kind, cmd_hi, cmd_lo);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (kind !== e.kind) begin
					$error("kind: expected %0d, got %0d", e.kind, kind); errors++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status); errors++;
				end
				if (cmd_hi !== e.cmd_hi) begin
					$error("cmd_hi: expected %h, got %h", e.cmd_hi, cmd_hi); errors++;
				end
				if (cmd_lo !== e.cmd_lo) begin
					$error("cmd_lo: expected %h, got %h", e.cmd_lo, cmd_lo); errors++;
				end
				if (payload !== e.payload) begin
					$error("payload: expected %h, got %h", e.payload, payload); errors++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last); errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Extremes, every op, bad indices, decimal-point-only positions
	task automatic test_directed();
		send_cmd(OP_INIT, 5'd31, 15'h7FFF);
		send_cmd(OP_BL, 5'd0, 15'h0);
		send_cmd(OP_FLUSH, 5'd0, 15'h0);    // nothing dirty yet
		send_cmd(OP_SYM, 5'd0, 15'h1);
		send_cmd(OP_SYM, 5'd18, 15'h7FFF);
		send_cmd(OP_SYM, 5'd19, 15'h1);     // bad index
		send_cmd(OP_DIG, 5'd0, 15'h00FF);   // decimal point only
		send_cmd(OP_DIG, 5'd3, 15'h7F7F);   // point off, segments ignored
		send_cmd(OP_DIG, 5'd2, 15'h7FFF);
		send_cmd(OP_DIG, 5'd10, 15'h007F);
		send_cmd(OP_DIG, 5'd11, 15'h7F);    // bad index
		send_cmd(OP_TCH, 5'd0, 15'h3FFF);
		send_cmd(OP_TCH, 5'd7, 15'h4000);   // middle lights both centers
		send_cmd(OP_TCH, 5'd8, 15'h1);      // bad index
		send_cmd(OP_BCH, 5'd0, 15'h7FFF);
		send_cmd(OP_BCH, 5'd3, 15'h4000);
		send_cmd(OP_BCH, 5'd4, 15'h1);      // bad index
		send_cmd(OP_FLUSH, 5'd31, 15'h7FFF);
		send_cmd(OP_CLR, 5'd7, 15'h1234);
		send_cmd(OP_FLUSH, 5'd0, 15'h0);    // nothing dirty after the flush and clear
		send_cmd(OP_FLUSH, 5'd0, 15'h0);
	endtask

	// Random commands, with flush, clear, backlight and init mixed in, plus noise
	task automatic test_random(int count);
		op_t o;
		logic [4:0] idx;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 12) o = OP_FLUSH;
			else if (r < 16) o = OP_CLR;
			else if (r < 19) o = OP_BL;
			else if (r < 22) o = OP_INIT;
			else o = op_t'($urandom_range(3));
			// mostly valid indices, a few out of range
			if ($urandom_range(9) == 0) idx = 5'($urandom);
			else case (o)
				OP_SYM: idx = 5'($urandom_range(18));
				OP_DIG: idx = 5'($urandom_range(10));
				OP_TCH: idx = 5'($urandom_range(7));
				OP_BCH: idx = 5'($urandom_range(3));
				default: idx = 5'($urandom);
			endcase
			send_cmd(o, idx, 15'($urandom));
		end
	endtask

	// Hold off the sender until the block has emptied, then continue
	task automatic test_pause_drain();
		send_cmd(OP_TCH, 5'd4, 15'h5A5A);
		send_cmd(OP_BCH, 5'd2, 15'h2A5A);
		drain_results();
		send_cmd(OP_FLUSH, 5'd0, 15'h0);
	endtask

	initial begin
		for (int i = 0; i < NPKT; i++) shadow_pl[i] = '0;
		shadow_dirty = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = '0;
		index = '0;
		value = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pause_drain();
		// no idling
		send_idle_pct = 0;  recv_stall_pct = 0;  test_random(120);
		send_idle_pct = 68; recv_stall_pct = 0;  test_random(110);
		send_idle_pct = 0;  recv_stall_pct = 68; test_random(110);
		send_idle_pct = 9;  recv_stall_pct = 9;  test_random(110);
		drain_results();

		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("covered %0d commands (sym %0d dig %0d tch %0d bch %0d clr %0d flush %0d)",
			sent_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
			op_seen[5]);
		$display("checked %0d results under four idle/stall mixes", result_count);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
design/slsp_pkg.sv
design/slsp_datapath.sv
design/slsp_ctrl.sv
design/segment_lcd_shadow_packer_core.sv
tb/sv/tb.sv
